### src/ssma_pkg.sv
// ----------------------------------------------------------------------------
// ssma_pkg
// Shared types and constants for the scaled sample moving average core:
// field widths, register map, reset values, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ssma_pkg;

  // default parameter values
  localparam int RingDepthDef = 64;
  localparam int CodeBitsDef  = 12;

  // fixed field widths
  localparam int ValueBits = 28;
  localparam int GainBits  = 16;
  localparam int WlenBits  = 7;
  localparam int AddrBits  = 4;
  localparam int DataBits  = 32;

  localparam logic [ValueBits-1:0] ValueMax = '1;

  // register reset values
  localparam logic [WlenBits-1:0] WlenReset = 7'd10;
  localparam logic [GainBits-1:0] GainReset = 16'd259;

  // register map, word index
  typedef enum logic [1:0] {
    REG_RUN    = 2'd0,
    REG_FILTER = 2'd1,
    REG_WINDOW = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_WRITE,
    S_SUM,
    S_PDIV,
    S_PWAIT,
    S_SDIV,
    S_SWAIT,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic scale_load;
    logic ring_write;
    logic sum_clear;
    logic sum_run;
    logic div_start;
    logic div_sel_ptr;
    logic ptr_load;
    logic out_load;
    logic out_sel_avg;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

### src/ssma_regs.sv
// ----------------------------------------------------------------------------
// ssma_regs
// APB-style configuration registers: run enable, filter enable, window
// length and scale gain, with read back.
// ----------------------------------------------------------------------------
module ssma_regs
  import ssma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output logic                run_en_o,
  output logic                filt_en_o,
  output logic [WlenBits-1:0] win_len_o,
  output logic [GainBits-1:0] gain_o
);

  logic                run_q;
  logic                filt_q;
  logic [WlenBits-1:0] wlen_q;
  logic [GainBits-1:0] gain_q;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      filt_q <= 1'b0;
      wlen_q <= WlenReset;
      gain_q <= GainReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_RUN:    run_q  <= pwdata[0];
        REG_FILTER: filt_q <= pwdata[0];
        REG_WINDOW: wlen_q <= pwdata[WlenBits-1:0];
        REG_GAIN:   gain_q <= pwdata[GainBits-1:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_RUN:    prdata = DataBits'(run_q);
      REG_FILTER: prdata = DataBits'(filt_q);
      REG_WINDOW: prdata = DataBits'(wlen_q);
      REG_GAIN:   prdata = DataBits'(gain_q);
      default:    prdata = '0;
    endcase
  end

  assign run_en_o  = run_q;
  assign filt_en_o = filt_q;
  assign win_len_o = wlen_q;
  assign gain_o    = gain_q;

endmodule

### src/ssma_div.sv
// ----------------------------------------------------------------------------
// ssma_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient
// and remainder once busy falls.
// ----------------------------------------------------------------------------
module ssma_div #(
  parameter int DivdW = 34,
  parameter int DsorW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivdW-1:0] dividend_i,
  input  logic [DsorW-1:0] divisor_i,
  output logic             busy_o,
  output logic [DivdW-1:0] quotient_o,
  output logic [DsorW-1:0] remainder_o
);

  localparam int CntW = $clog2(DivdW + 1);

  logic [DivdW-1:0] quo_q, quo_d;
  logic [DsorW-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DsorW:0]   trial;
  logic [DsorW:0]   diff;
  logic             fits;

  // one restoring step
  assign trial = {rem_q, quo_q[DivdW-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CntW'(DivdW);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[DivdW-2:0], fits};
      rem_d = fits ? diff[DsorW-1:0] : trial[DsorW-1:0];
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o      = cnt_q != '0;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### src/ssma_dp.sv
// ----------------------------------------------------------------------------
// ssma_dp
// Datapath: gain multiplier, sample ring with per-slot valid bits, write
// pointer, sweep accumulator, shared divider and the output register.
// ----------------------------------------------------------------------------
module ssma_dp
  import ssma_pkg::*;
#(
  parameter int RingDepth = RingDepthDef,
  parameter int CodeBits  = CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [CodeBits-1:0]  sample_code_i,
  input  logic [WlenBits-1:0]  win_len_i,
  input  logic [GainBits-1:0]  gain_i,
  output logic [ValueBits-1:0] filtered_value_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  localparam int PtrW  = $clog2(RingDepth);
  localparam int WinW  = $clog2(RingDepth + 1);
  localparam int CmpW  = (WinW > WlenBits) ? WinW : WlenBits;
  localparam int SumW  = ValueBits + PtrW;
  localparam int ProdW = CodeBits + GainBits;
  localparam int ExtW  = (ProdW > ValueBits) ? ProdW : ValueBits;

  logic [ProdW-1:0]     prod_q;
  logic [ExtW-1:0]      prod_ext;
  logic [ValueBits-1:0] scaled;
  logic [CmpW-1:0]      wlen_ext;
  logic [WinW-1:0]      win;
  logic [PtrW-1:0]      ptr_q;
  logic [ValueBits-1:0] ring_mem [RingDepth];
  logic [RingDepth-1:0] vld_q;
  logic [ValueBits-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic                 pend_q;
  logic [WinW-1:0]      cnt_q;
  logic                 rd_en;
  logic [SumW-1:0]      acc_q;
  logic [SumW-1:0]      div_dividend;
  logic                 div_busy;
  logic [SumW-1:0]      div_quo;
  logic [WinW-1:0]      div_rem;
  logic [ValueBits-1:0] out_q;
  logic                 out_vld_q;

  // scale by the gain, registered straight after the multiplier
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_load) begin
      prod_q <= sample_code_i * gain_i;
    end
  end

  // saturate to the value width
  assign prod_ext = ExtW'(prod_q);
  assign scaled   = (prod_ext > ExtW'(ValueMax)) ? ValueMax : prod_ext[ValueBits-1:0];

  // effective window: zero reads as one, clipped to the ring depth
  assign wlen_ext = CmpW'(win_len_i);
  always_comb begin
    if (wlen_ext == '0) begin
      win = WinW'(1);
    end else if (wlen_ext > CmpW'(RingDepth)) begin
      win = WinW'(RingDepth);
    end else begin
      win = wlen_ext[WinW-1:0];
    end
  end

  // sweep read enable
  assign rd_en = cmd_i.sum_run && (cnt_q != win);

  // ring memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_write) begin
      ring_mem[ptr_q] <= scaled;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[cnt_q[PtrW-1:0]];
    end
  end

  // slot valid bits, a slot never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.ring_write) begin
        vld_q[ptr_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[cnt_q[PtrW-1:0]];
      end
    end
  end

  // sweep counter and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.sum_clear) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.sum_run) begin
      pend_q <= rd_en;
      if (rd_en) begin
        cnt_q <= cnt_q + WinW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clear) begin
      acc_q <= '0;
    end else if (cmd_i.sum_run && pend_q && rd_vld_q) begin
      acc_q <= acc_q + SumW'(rd_data_q);
    end
  end

  assign sts_o.sum_done = (cnt_q == win) && !pend_q;

  // shared divider: pointer wrap first, then the mean
  assign div_dividend = cmd_i.div_sel_ptr ? (SumW'(ptr_q) + SumW'(1)) : acc_q;

  ssma_div #(
    .DivdW (SumW),
    .DsorW (WinW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (win),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign sts_o.div_busy = div_busy;

  // write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_load) begin
      ptr_q <= div_rem[PtrW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_sel_avg ? div_quo[ValueBits-1:0] : scaled;
    end
  end

  assign sts_o.out_free   = !out_vld_q || out_ready_i;
  assign filtered_value_o = out_q;
  assign out_valid_o      = out_vld_q;

endmodule

### src/ssma_ctrl.sv
// ----------------------------------------------------------------------------
// ssma_ctrl
// Controller: sequences scaling, ring write, window sweep, pointer wrap,
// mean division and hand-off to the output register.
// ----------------------------------------------------------------------------
module ssma_ctrl
  import ssma_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic run_en_i,
  input  logic filt_en_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && run_en_i) state_d = S_SCALE;
      S_SCALE: state_d = filt_en_i ? S_WRITE : S_OUT;
      S_WRITE: state_d = S_SUM;
      S_SUM:   if (sts_i.sum_done) state_d = S_PDIV;
      S_PDIV:  state_d = S_PWAIT;
      S_PWAIT: if (!sts_i.div_busy) state_d = S_SDIV;
      S_SDIV:  state_d = S_SWAIT;
      S_SWAIT: if (!sts_i.div_busy) state_d = S_OUT;
      S_OUT:   if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.scale_load = accept;
      S_WRITE: begin
        cmd_o.ring_write = 1'b1;
        cmd_o.sum_clear  = 1'b1;
      end
      S_SUM:   cmd_o.sum_run = 1'b1;
      S_PDIV:  begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_ptr = 1'b1;
      end
      S_PWAIT: cmd_o.ptr_load = !sts_i.div_busy;
      S_SDIV:  cmd_o.div_start = 1'b1;
      S_OUT:   begin
        cmd_o.out_load    = sts_i.out_free;
        cmd_o.out_sel_avg = filt_en_i;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### src/scaled_sample_moving_average_core.sv
// ----------------------------------------------------------------------------
// scaled_sample_moving_average_core
// Scales each converter code by a Q8.8 gain and either passes the scaled
// value or gives the truncated mean over a ring of recent values.
//
// Input channel sample_code_i / in_valid_i / in_ready_o takes one code per
// request; output channel filtered_value_o / out_valid_o / out_ready_i gives
// at most one result per request. Nothing comes out while run is off.
// The block works on one request at a time; in_ready_o is high only while
// the controller is idle. Pass-through goes from the scale step straight
// to the output step, which loads the result register once it is free.
// With the filter on, the scaled value is written to the ring, the window
// of W ring slots is swept into the accumulator, W the window length,
// then two passes go through the bit-serial divider on a dividend of
// 28 + log2(ring depth) bits (34 at the default depth), first for the
// pointer wrap, then for the mean.
// A finished result sits in the output register; a stalled receiver holds
// only the next result, the next request is accepted meanwhile.
// Reset clears the controller, pointer, slot valid bits and registers at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scaled_sample_moving_average_core
  import ssma_pkg::*;
#(
  parameter int RING_DEPTH = RingDepthDef,
  parameter int CODE_BITS  = CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrBits-1:0]  paddr,
  input  logic [DataBits-1:0]  pwdata,
  output logic [DataBits-1:0]  prdata,
  output logic                 pready,
  input  logic [CODE_BITS-1:0] sample_code_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic [ValueBits-1:0] filtered_value_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);

  logic                run_en;
  logic                filt_en;
  logic [WlenBits-1:0] win_len;
  logic [GainBits-1:0] gain;
  cmd_t                cmd;
  sts_t                sts;

  // configuration registers
  ssma_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .run_en_o  (run_en),
    .filt_en_o (filt_en),
    .win_len_o (win_len),
    .gain_o    (gain)
  );

  // sequencing
  ssma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .run_en_i   (run_en),
    .filt_en_i  (filt_en),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  ssma_dp #(
    .RingDepth (RING_DEPTH),
    .CodeBits  (CODE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_code_i    (sample_code_i),
    .win_len_i        (win_len),
    .gain_i           (gain),
    .filtered_value_o (filtered_value_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i)
  );

  // divider never restarted mid-run
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // an unclaimed result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // idle controller leaves the divider quiet
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.div_busy)
    else $error("divider busy while idle");

  // a new result follows a load of the output register
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) && !cmd.out_load |=> !out_valid_o)
    else $error("result appeared without a load");

endmodule
